// ----- hw/rtl/tcpg_pkg.sv -----
// tcpg_pkg: shared types, constants and codes of the text cell pixel generator
// used by every module under hw/rtl; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package tcpg_pkg;

  // glyph store geometry
  localparam int GLYPH_LINES   = 16;
  localparam int LINE_W        = $clog2(GLYPH_LINES);
  localparam int CODE_W        = 8;
  localparam int GLYPH_ADDR_W  = 12;
  localparam int GLYPH_DEPTH   = 1 << GLYPH_ADDR_W;
  localparam int GLYPH_W       = 8;

  // pixel output
  localparam int NUM_PIXELS    = 7;
  localparam int PIX_W         = 4;
  localparam int OUT_TDATA_W   = 32;

  // input stream: glyph_address, glyph_data, char_code, colour_byte,
  // cell_address, scan_line from bit 0 up
  localparam int CELL_ADDR_W   = 12;
  localparam int COLOUR_W      = 8;
  localparam int IN_TDATA_W    = 56;
  localparam int OP_W          = 2;

  // configuration port
  localparam int CFG_INDEX_W   = 3;
  localparam int CFG_DATA_W    = 14;
  localparam int SCAN_W        = 5;
  localparam int START_MODE_W  = 7;
  localparam int CUR_ADDR_W    = 14;
  localparam int COLOUR_MODE_W = 2;

  // cursor start mode fields
  localparam int MODE_SPEED_BIT = 5;
  localparam int MODE_FLASH_BIT = 6;

  // frame counter bits that pace the blink
  localparam int FRAME_W         = 8;
  localparam int FRAME_FAST_BIT  = 3;
  localparam int FRAME_SLOW_BIT  = 4;

  // fixed colours
  localparam logic [PIX_W-1:0] COLOUR_GREEN = 4'd5;
  localparam logic [PIX_W-1:0] COLOUR_WHITE = 4'd15;

  // request kinds carried in tuser
  typedef enum logic [OP_W-1:0] {
    OP_WRITE_GLYPH = 2'd0,
    OP_FRAME_START = 2'd1,
    OP_RENDER      = 2'd2,
    OP_IGNORED     = 2'd3
  } op_e;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LAST_SCAN_LINE    = 3'd0,
    REG_CURSOR_START_MODE = 3'd1,
    REG_CURSOR_END_LINE   = 3'd2,
    REG_CURSOR_ADDRESS    = 3'd3,
    REG_COLOUR_MODE       = 3'd4,
    REG_INVERSE_ENABLE    = 3'd5
  } cfg_reg_e;

  // configuration register file contents
  typedef struct packed {
    logic [SCAN_W-1:0]        last_scan_line;
    logic [START_MODE_W-1:0]  cursor_start_mode;
    logic [SCAN_W-1:0]        cursor_end_line;
    logic [CUR_ADDR_W-1:0]    cursor_address;
    logic [COLOUR_MODE_W-1:0] colour_mode;
    logic                     inverse_enable;
  } cfg_t;

  // per-cell attributes that travel beside the glyph read
  typedef struct packed {
    logic [PIX_W-1:0] fg;
    logic [PIX_W-1:0] bg;
    logic             invert;
  } attr_t;

endpackage

`default_nettype wire

// ----- hw/rtl/tcpg_glyph_ram.sv -----
// tcpg_glyph_ram: 4096 x 8 glyph store, one write port and one registered read port
// depends on tcpg_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcpg_glyph_ram
  import tcpg_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    wr_en_i,
  input  wire logic [GLYPH_ADDR_W-1:0] wr_addr_i,
  input  wire logic [GLYPH_W-1:0]      wr_data_i,
  input  wire logic                    rd_en_i,
  input  wire logic [GLYPH_ADDR_W-1:0] rd_addr_i,
  output logic      [GLYPH_W-1:0]      rd_data_o
);

  logic [GLYPH_W-1:0] mem_q [GLYPH_DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tcpg_ctrl.sv -----
// tcpg_ctrl: configuration registers, frame counter, cursor decode and
// glyph address / colour selection for one cell; depends on tcpg_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcpg_ctrl
  import tcpg_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    cfg_valid_i,
  input  wire logic [CFG_INDEX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]   cfg_data_i,
  input  wire logic                    frame_inc_i,
  input  wire logic [CODE_W-1:0]       char_code_i,
  input  wire logic [COLOUR_W-1:0]     colour_byte_i,
  input  wire logic [CELL_ADDR_W-1:0]  cell_address_i,
  input  wire logic [LINE_W-1:0]       scan_line_i,
  output logic      [GLYPH_ADDR_W-1:0] glyph_rd_addr_o,
  output attr_t                        attr_o
);

  cfg_t               cfg_q;
  logic [FRAME_W-1:0] frame_q;

  logic [SCAN_W-1:0]  cur_s;
  logic [SCAN_W:0]    cur_e;
  logic [SCAN_W:0]    cur_e_cap;
  logic [SCAN_W:0]    line_x;
  logic               speed, flash;
  logic               phase_shown;
  logic               line_lit;
  logic               cursor_hit;
  logic               high_inv;
  logic [CODE_W-1:0]  code_eff;

  // configuration writes, unknown indexes dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{last_scan_line:    '0,
                 cursor_start_mode: '0,
                 cursor_end_line:   '0,
                 cursor_address:    '0,
                 colour_mode:       '0,
                 inverse_enable:    1'b1};
    end else if (cfg_valid_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_LAST_SCAN_LINE:    cfg_q.last_scan_line    <= cfg_data_i[SCAN_W-1:0];
        REG_CURSOR_START_MODE: cfg_q.cursor_start_mode <= cfg_data_i[START_MODE_W-1:0];
        REG_CURSOR_END_LINE:   cfg_q.cursor_end_line   <= cfg_data_i[SCAN_W-1:0];
        REG_CURSOR_ADDRESS:    cfg_q.cursor_address    <= cfg_data_i[CUR_ADDR_W-1:0];
        REG_COLOUR_MODE:       cfg_q.colour_mode       <= cfg_data_i[COLOUR_MODE_W-1:0];
        REG_INVERSE_ENABLE:    cfg_q.inverse_enable    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // frame counter, wraps naturally
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_q <= '0;
    end else if (frame_inc_i) begin
      frame_q <= frame_q + FRAME_W'(1);
    end
  end

  // blink phase
  always_comb begin
    speed = cfg_q.cursor_start_mode[MODE_SPEED_BIT];
    flash = cfg_q.cursor_start_mode[MODE_FLASH_BIT];
    unique case ({flash, speed})
      2'b00:   phase_shown = 1'b1;
      2'b01:   phase_shown = 1'b0;
      2'b11:   phase_shown = frame_q[FRAME_SLOW_BIT];
      default: phase_shown = frame_q[FRAME_FAST_BIT];
    endcase
  end

  // cursor line shape: normal, split, full or none
  always_comb begin
    cur_s     = cfg_q.cursor_start_mode[SCAN_W-1:0];
    cur_e     = {1'b0, cfg_q.cursor_end_line} + (SCAN_W+1)'(1);
    cur_e_cap = (cur_e > (SCAN_W+1)'(GLYPH_LINES)) ? (SCAN_W+1)'(GLYPH_LINES) : cur_e;
    line_x    = (SCAN_W+1)'(scan_line_i);
    priority if (cur_s > cfg_q.last_scan_line) begin
      line_lit = 1'b0;
    end else if (cfg_q.cursor_end_line > cfg_q.last_scan_line) begin
      line_lit = 1'b1;
    end else if ({1'b0, cur_s} < cur_e) begin
      line_lit = (line_x >= {1'b0, cur_s}) && (line_x < cur_e_cap);
    end else if ({1'b0, cur_s} == cur_e) begin
      line_lit = 1'b1;
    end else begin
      line_lit = !((line_x >= cur_e_cap) && (line_x < {1'b0, cur_s}));
    end
  end

  // glyph address and cell attributes
  always_comb begin
    high_inv   = cfg_q.inverse_enable && char_code_i[CODE_W-1];
    code_eff   = high_inv ? {1'b0, char_code_i[CODE_W-2:0]} : char_code_i;
    cursor_hit = (cfg_q.cursor_address == CUR_ADDR_W'(cell_address_i))
                 && phase_shown && line_lit;
    glyph_rd_addr_o = {code_eff, scan_line_i};
    attr_o.invert   = high_inv ^ cursor_hit;
    if (!cfg_q.colour_mode[1]) begin
      attr_o.fg = colour_byte_i[PIX_W-1:0];
      attr_o.bg = colour_byte_i[COLOUR_W-1:PIX_W];
    end else begin
      attr_o.fg = cfg_q.colour_mode[0] ? COLOUR_WHITE : COLOUR_GREEN;
      attr_o.bg = '0;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/tcpg_pixel_out.sv -----
// tcpg_pixel_out: expands one glyph byte into seven colour indices and holds
// the result register of the output stream; depends on tcpg_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcpg_pixel_out
  import tcpg_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   in_valid_i,
  input  wire attr_t                  in_attr_i,
  input  wire logic [GLYPH_W-1:0]     in_glyph_i,
  output logic                        in_ready_o,
  output logic                        out_valid_o,
  input  wire logic                   out_ready_i,
  output logic      [OUT_TDATA_W-1:0] out_data_o
);

  logic [GLYPH_W-1:0]     gfx;
  logic [OUT_TDATA_W-1:0] pix_d;

  assign in_ready_o = !out_valid_o || out_ready_i;

  // pixel k shows glyph bit 7-k
  always_comb begin
    gfx   = in_glyph_i ^ {GLYPH_W{in_attr_i.invert}};
    pix_d = '0;
    for (int k = 0; k < NUM_PIXELS; k++) begin
      pix_d[k*PIX_W +: PIX_W] = gfx[GLYPH_W-1-k] ? in_attr_i.fg : in_attr_i.bg;
    end
  end

  // result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_o <= in_valid_i;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      out_data_o <= pix_d;
    end
  end

endmodule

`default_nettype wire

// ----- hw/rtl/text_cell_pixel_generator_with_cursor.sv -----
// Text cell pixel generator with cursor, top level.
// Slave stream: tuser carries the request kind (write glyph byte, frame start,
// render cell line); tdata carries glyph_address, glyph_data, char_code,
// colour_byte, cell_address and scan_line. Only render requests give a result.
// Master stream: tdata carries pixel_0 .. pixel_6, 4 bits each, leftmost first.
// Configuration: cfg_valid_i / cfg_index_i / cfg_data_i, always ready; write
// only while no request is in flight.
// Pipeline: an accepted render request passes the registered glyph store read
// stage, then the output register, and is offered on the master side from the
// output register.
// Throughput is one request per cycle while the receiver keeps up; the glyph
// store's single read port and single write port set that figure.
// Stalls: the read stage and the output register each hold one result, so one
// more render request is taken while a result waits; after that s_axis_tready
// drops until the receiver takes the waiting result.
// Reset: clears stage valids, the frame counter and the configuration
// registers (inverse enable comes up set); the glyph store is not cleared and
// must be written before a glyph entry is rendered.
`timescale 1ns / 1ps
`default_nettype none

module text_cell_pixel_generator_with_cursor
  import tcpg_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  // slave stream
  input  wire logic                   s_axis_tvalid,
  output logic                        s_axis_tready,
  // glyph_address[11:0], glyph_data[19:12], char_code[27:20],
  // colour_byte[35:28], cell_address[47:36], scan_line[51:48], zero pad
  input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // operation[1:0]
  input  wire logic [OP_W-1:0]        s_axis_tuser,
  // master stream
  output logic                        m_axis_tvalid,
  input  wire logic                   m_axis_tready,
  // pixel_0[3:0], pixel_1[7:4], ... pixel_6[27:24], zero pad
  output logic      [OUT_TDATA_W-1:0] m_axis_tdata,
  // configuration write channel
  input  wire logic                   cfg_valid_i,
  output logic                        cfg_ready_o,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [GLYPH_ADDR_W-1:0] in_glyph_addr;
  logic [GLYPH_W-1:0]      in_glyph_data;
  logic [CODE_W-1:0]       in_char_code;
  logic [COLOUR_W-1:0]     in_colour_byte;
  logic [CELL_ADDR_W-1:0]  in_cell_address;
  logic [LINE_W-1:0]       in_scan_line;
  op_e                     in_op;

  logic                    accept;
  logic                    rd_vld_q;
  attr_t                   attr_d, attr_q;
  logic [GLYPH_ADDR_W-1:0] rd_addr;
  logic [GLYPH_W-1:0]      rd_data;
  logic                    out_ready;
  logic                    rd_stage_en;

  // unpack the request
  assign in_glyph_addr   = s_axis_tdata[11:0];
  assign in_glyph_data   = s_axis_tdata[19:12];
  assign in_char_code    = s_axis_tdata[27:20];
  assign in_colour_byte  = s_axis_tdata[35:28];
  assign in_cell_address = s_axis_tdata[47:36];
  assign in_scan_line    = s_axis_tdata[51:48];
  assign in_op           = op_e'(s_axis_tuser);

  // read stage advances when empty or when the output side can take it
  assign rd_stage_en   = !rd_vld_q || out_ready;
  assign s_axis_tready = rd_stage_en;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  tcpg_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .frame_inc_i     (accept && (in_op == OP_FRAME_START)),
    .char_code_i     (in_char_code),
    .colour_byte_i   (in_colour_byte),
    .cell_address_i  (in_cell_address),
    .scan_line_i     (in_scan_line),
    .glyph_rd_addr_o (rd_addr),
    .attr_o          (attr_d)
  );

  tcpg_glyph_ram u_glyph_ram (
    .clk_i     (clk_i),
    .wr_en_i   (accept && (in_op == OP_WRITE_GLYPH)),
    .wr_addr_i (in_glyph_addr),
    .wr_data_i (in_glyph_data),
    .rd_en_i   (rd_stage_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // read stage valid: only render requests produce a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q <= 1'b0;
    end else if (rd_stage_en) begin
      rd_vld_q <= accept && (in_op == OP_RENDER);
    end
  end

  // attributes travel beside the glyph read
  always_ff @(posedge clk_i) begin
    if (rd_stage_en) begin
      attr_q <= attr_d;
    end
  end

  tcpg_pixel_out u_pixel_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (rd_vld_q),
    .in_attr_i   (attr_q),
    .in_glyph_i  (rd_data),
    .in_ready_o  (out_ready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

`default_nettype wire

// ----- hw/rtl/tcpg_checker.sv -----
// tcpg_checker: port-level assertions for the text cell pixel generator,
// bound to the top level; depends on tcpg_pkg
`timescale 1ns / 1ps
`default_nettype none

module tcpg_checker
  import tcpg_pkg::*;
(
  input wire logic                   clk_i,
  input wire logic                   rst_ni,
  input wire logic                   s_axis_tready,
  input wire logic                   m_axis_tvalid,
  input wire logic                   m_axis_tready,
  input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input wire logic                   cfg_ready_o
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // a stalled result keeps its pixels
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // requests are only refused while a result waits on a stalled receiver
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
    else $error("request refused without a stalled result");

  // padding above the seven pixels is zero and config is taken while a result is offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[OUT_TDATA_W-1:NUM_PIXELS*PIX_W] == '0) && cfg_ready_o)
    else $error("bad result padding or config refused");

endmodule

bind text_cell_pixel_generator_with_cursor tcpg_checker u_tcpg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .cfg_ready_o   (cfg_ready_o)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// tb_top: self-checking bench for the text cell pixel generator with cursor
// drives glyph writes, frame starts and cell line renders under several register settings
// depends on tcpg_pkg and text_cell_pixel_generator_with_cursor
`timescale 1ns / 1ps

module tb_top;
  import tcpg_pkg::*;

  localparam realtime CLK_HALF        = 2.0;
  localparam int      RESET_CYCLES    = 12;
  localparam int      CYCLE_LIMIT     = 200000;
  localparam int      NUM_PHASES      = 12;
  localparam int      NUM_FIXED       = 8;
  localparam int      PHASE_ITEMS     = 100;
  localparam int      HOLD_OFF_CYCLES = 400;
  localparam int      SETTLE_CYCLES   = 6;
  localparam int      MAX_REPORTS     = 10;
  localparam int      NUM_DIRECTED    = 22;

  // one row of pixels, pixel_0 in the lowest nibble
  typedef logic [NUM_PIXELS-1:0][PIX_W-1:0] pix_row_t;

  typedef struct packed {
    op_e                     op;
    logic [GLYPH_ADDR_W-1:0] glyph_addr;
    logic [GLYPH_W-1:0]      glyph_byte;
    logic [CODE_W-1:0]       code;
    logic [COLOUR_W-1:0]     colour;
    logic [CELL_ADDR_W-1:0]  cell_addr;
    logic [LINE_W-1:0]       line;
  } cell_req_t;

  typedef struct packed {
    cell_req_t req;
    logic      typed;
    pix_row_t  pix;
  } directed_row_t;

  typedef enum {SHAPE_NONE, SHAPE_BAND, SHAPE_FULL, SHAPE_SPLIT} cursor_shape_e;

  // dut signals
  logic                   clk_i;
  logic                   rst_ni        = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [OP_W-1:0]        s_axis_tuser  = '0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_valid_i   = 1'b0;
  logic                   cfg_ready_o;
  logic [CFG_INDEX_W-1:0] cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i    = '0;

  // mirror of the block state
  logic [GLYPH_W-1:0] glyph_mirror  [GLYPH_DEPTH];
  bit                 glyph_written [GLYPH_DEPTH];
  logic [FRAME_W-1:0] frame_ctr = '0;
  cfg_t               reg_shadow;
  pix_row_t           pixel_rows_due [$];

  // traffic control and bookkeeping
  int unsigned tx_idle_pct    = 0;
  int unsigned rx_stall_pct   = 0;
  int unsigned rx_hold        = 0;
  int unsigned cycle_count    = 0;
  int unsigned mismatch_count = 0;
  int unsigned rows_checked   = 0;
  int unsigned requests_taken = 0;
  int unsigned writes_taken   = 0;
  int unsigned frames_taken   = 0;
  int unsigned ignored_taken  = 0;
  int unsigned settings_done  = 0;

  // directed requests; typed rows carry a hand-worked pixel row
  directed_row_t directed_rows [NUM_DIRECTED] = '{
    '{'{OP_WRITE_GLYPH, 12'h410, 8'hA5, 8'h00, 8'h00, 12'h000, 4'h0}, 1'b0, 28'h0},
    '{'{OP_RENDER,      12'h000, 8'h00, 8'h41, 8'h1E, 12'h005, 4'h0}, 1'b1, 28'h1E11E1E},
    // high code drawn inverted
    '{'{OP_RENDER,      12'h000, 8'h00, 8'hC1, 8'h1E, 12'h005, 4'h0}, 1'b1, 28'hE1EE1E1},
    // cursor cell on the one lit line
    '{'{OP_RENDER,      12'h000, 8'h00, 8'h41, 8'h1E, 12'h000, 4'h0}, 1'b1, 28'hE1EE1E1},
    // inverse and cursor cancel
    '{'{OP_RENDER,      12'h000, 8'h00, 8'hC1, 8'h1E, 12'h000, 4'h0}, 1'b1, 28'h1E11E1E},
    '{'{OP_WRITE_GLYPH, 12'hFFF, 8'hFF, 8'h00, 8'h00, 12'h000, 4'h0}, 1'b0, 28'h0},
    '{'{OP_WRITE_GLYPH, 12'h7FF, 8'h00, 8'h00, 8'h00, 12'h000, 4'h0}, 1'b0, 28'h0},
    '{'{OP_RENDER,      12'h000, 8'h00, 8'hFF, 8'h0F, 12'hFFF, 4'hF}, 1'b1, 28'hFFFFFFF},
    '{'{OP_RENDER,      12'h000, 8'h00, 8'h7F, 8'h30, 12'hFFF, 4'hF}, 1'b1, 28'h3333333},
    '{'{OP_WRITE_GLYPH, 12'h000, 8'h81, 8'h00, 8'h00, 12'h000, 4'h0}, 1'b0, 28'h0},
    '{'{OP_RENDER,      12'h000, 8'h00, 8'h00, 8'hA5, 12'h000, 4'h0}, 1'b1, 28'h555555A},
    '{'{OP_RENDER,      12'h000, 8'h00, 8'h00, 8'hA5, 12'h001, 4'h0}, 1'b1, 28'hAAAAAA5},
    '{'{OP_FRAME_START, 12'h000, 8'h00, 8'h00, 8'h00, 12'h000, 4'h0}, 1'b0, 28'h0},
    // unused request kind with every field bit set
    '{'{OP_IGNORED,     12'hFFF, 8'hFF, 8'hFF, 8'hFF, 12'hFFF, 4'hF}, 1'b0, 28'h0},
    '{'{OP_RENDER,      12'h000, 8'h00, 8'h41, 8'h1E, 12'h000, 4'h0}, 1'b0, 28'h0},
    '{'{OP_WRITE_GLYPH, 12'h411, 8'h3C, 8'h00, 8'h00, 12'h000, 4'h0}, 1'b0, 28'h0},
    '{'{OP_RENDER,      12'h000, 8'h00, 8'h41, 8'h7C, 12'h000, 4'h1}, 1'b0, 28'h0},
    '{'{OP_WRITE_GLYPH, 12'h000, 8'h00, 8'h00, 8'h00, 12'h000, 4'h0}, 1'b0, 28'h0},
    '{'{OP_RENDER,      12'h000, 8'h00, 8'h80, 8'hFF, 12'h000, 4'h0}, 1'b0, 28'h0},
    '{'{OP_IGNORED,     12'h000, 8'h00, 8'h00, 8'h00, 12'h000, 4'h0}, 1'b0, 28'h0},
    '{'{OP_FRAME_START, 12'h000, 8'h00, 8'h00, 8'h00, 12'h000, 4'h0}, 1'b0, 28'h0},
    '{'{OP_RENDER,      12'h000, 8'h00, 8'hC1, 8'h00, 12'h005, 4'h0}, 1'b0, 28'h0}
  };

  text_cell_pixel_generator_with_cursor i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  // run limit
  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  // scan lines that carry the cursor under the current shape registers
  function automatic bit cursor_on_line(input logic [LINE_W-1:0] line);
    int unsigned   first;
    int unsigned   stop;
    int unsigned   last;
    cursor_shape_e shape;
    first = 32'(reg_shadow.cursor_start_mode[SCAN_W-1:0]);
    stop  = 32'(reg_shadow.cursor_end_line) + 32'd1;
    last  = 32'(reg_shadow.last_scan_line);
    if (first < stop) shape = SHAPE_BAND;
    else if (first == stop) shape = SHAPE_FULL;
    else shape = SHAPE_SPLIT;
    // end beyond the row draws a full block, start beyond the row hides it
    if (stop - 1 > last) shape = SHAPE_FULL;
    if (first > last) shape = SHAPE_NONE;
    if (stop > GLYPH_LINES) stop = GLYPH_LINES;
    case (shape)
      SHAPE_BAND:  return line >= first && line < stop;
      SHAPE_FULL:  return 1'b1;
      SHAPE_SPLIT: return !(line >= stop && line < first);
      default:     return 1'b0;
    endcase
  endfunction

  // blink phase from the flash and speed bits
  function automatic bit cursor_blink_on();
    logic speed;
    logic flash;
    speed = reg_shadow.cursor_start_mode[MODE_SPEED_BIT];
    flash = reg_shadow.cursor_start_mode[MODE_FLASH_BIT];
    if (!flash) return !speed;
    return speed ? frame_ctr[FRAME_SLOW_BIT] : frame_ctr[FRAME_FAST_BIT];
  endfunction

  // pixel row for one rendered cell line
  function automatic pix_row_t render_cell_line(input cell_req_t r);
    logic [PIX_W-1:0]   fg;
    logic [PIX_W-1:0]   bg;
    logic [GLYPH_W-1:0] flip;
    logic [GLYPH_W-1:0] glyph;
    logic [CODE_W-1:0]  code;
    pix_row_t           row;
    fg = (reg_shadow.colour_mode == 2'd3) ? COLOUR_WHITE : COLOUR_GREEN;
    bg = '0;
    if (!reg_shadow.colour_mode[1]) begin
      fg = r.colour[PIX_W-1:0];
      bg = r.colour[COLOUR_W-1:PIX_W];
    end
    code = r.code;
    flip = '0;
    if (reg_shadow.inverse_enable && code[CODE_W-1]) begin
      flip = '1;
      code[CODE_W-1] = 1'b0;
    end
    if ({2'b00, r.cell_addr} == reg_shadow.cursor_address && cursor_blink_on() &&
        cursor_on_line(r.line)) begin
      flip = ~flip;
    end
    glyph = glyph_mirror[{code, r.line}] ^ flip;
    for (int k = 0; k < NUM_PIXELS; k++) row[k] = glyph[GLYPH_W-1-k] ? fg : bg;
    return row;
  endfunction

  // offer one request, wait for it to be taken, then update the mirror
  task automatic push_request(input cell_req_t r, input logic typed, input pix_row_t typed_row);
    @(negedge clk_i);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.op;
    s_axis_tdata  <= {4'b0000, r.line, r.cell_addr, r.colour, r.code, r.glyph_byte,
                      r.glyph_addr};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    case (r.op)
      OP_WRITE_GLYPH: begin
        glyph_mirror[r.glyph_addr]  = r.glyph_byte;
        glyph_written[r.glyph_addr] = 1'b1;
        writes_taken++;
      end
      OP_FRAME_START: begin
        frame_ctr++;
        frames_taken++;
      end
      OP_RENDER: pixel_rows_due.push_back(typed ? typed_row : render_cell_line(r));
      default: ignored_taken++;
    endcase
    if (r.op != OP_IGNORED) requests_taken++;
  endtask

  // one random request; a render whose glyph entry is still blank gets it written first
  task automatic random_request();
    cell_req_t          r;
    cell_req_t          fill;
    int unsigned        pick;
    logic [CODE_W-1:0]  stored;
    r.glyph_addr = GLYPH_ADDR_W'($urandom);
    r.glyph_byte = GLYPH_W'($urandom);
    r.code       = CODE_W'($urandom);
    r.colour     = COLOUR_W'($urandom);
    r.cell_addr  = CELL_ADDR_W'($urandom);
    r.line       = LINE_W'($urandom);
    pick = $urandom_range(99);
    if (pick < 3) r.op = OP_IGNORED;
    else if (pick < 20) r.op = OP_WRITE_GLYPH;
    else if (pick < 50) r.op = OP_FRAME_START;
    else begin
      r.op = OP_RENDER;
      // keep most codes in a small set so glyph entries get reused
      if ($urandom_range(9) < 7) r.code[6:4] = 3'b010;
      if ($urandom_range(9) < 4) r.cell_addr = reg_shadow.cursor_address[CELL_ADDR_W-1:0];
      stored = r.code;
      if (reg_shadow.inverse_enable) stored[CODE_W-1] = 1'b0;
      if (!glyph_written[{stored, r.line}]) begin
        fill            = r;
        fill.op         = OP_WRITE_GLYPH;
        fill.glyph_addr = {stored, r.line};
        fill.glyph_byte = GLYPH_W'($urandom);
        push_request(fill, 1'b0, '0);
      end
    end
    push_request(r, 1'b0, '0);
  endtask

  // register write, shadow updated once the write is taken
  task automatic write_register(input cfg_reg_e idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      REG_LAST_SCAN_LINE:    reg_shadow.last_scan_line    = value[SCAN_W-1:0];
      REG_CURSOR_START_MODE: reg_shadow.cursor_start_mode = value[START_MODE_W-1:0];
      REG_CURSOR_END_LINE:   reg_shadow.cursor_end_line   = value[SCAN_W-1:0];
      REG_CURSOR_ADDRESS:    reg_shadow.cursor_address    = value[CUR_ADDR_W-1:0];
      REG_COLOUR_MODE:       reg_shadow.colour_mode       = value[COLOUR_MODE_W-1:0];
      REG_INVERSE_ENABLE:    reg_shadow.inverse_enable    = value[0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(input cfg_t s);
    write_register(REG_LAST_SCAN_LINE, CFG_DATA_W'(s.last_scan_line));
    write_register(REG_CURSOR_START_MODE, CFG_DATA_W'(s.cursor_start_mode));
    write_register(REG_CURSOR_END_LINE, CFG_DATA_W'(s.cursor_end_line));
    write_register(REG_CURSOR_ADDRESS, CFG_DATA_W'(s.cursor_address));
    write_register(REG_COLOUR_MODE, CFG_DATA_W'(s.colour_mode));
    write_register(REG_INVERSE_ENABLE, CFG_DATA_W'(s.inverse_enable));
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    settings_done++;
  endtask

  // hand-picked settings: cursor shapes, blink modes, colour modes, extremes
  function automatic cfg_t fixed_setting(input int n);
    case (n)
      1:       return '{5'd15, 7'h02, 5'd5,  14'h0010, 2'd0, 1'b1}; // band, always on
      2:       return '{5'd15, 7'h26, 5'd5,  14'h0123, 2'd1, 1'b1}; // start one past end, off
      3:       return '{5'd15, 7'h6A, 5'd3,  14'h0FFF, 2'd2, 1'b0}; // two-part, slow blink
      4:       return '{5'd7,  7'h42, 5'd12, 14'h0800, 2'd3, 1'b1}; // end past row, fast
      5:       return '{5'd7,  7'h09, 5'd12, 14'h2001, 2'd0, 1'b0}; // start past row
      6:       return '{5'd31, 7'h7F, 5'd31, 14'h3FFF, 2'd3, 1'b0};
      7:       return '{5'd0,  7'h00, 5'd0,  14'h0000, 2'd0, 1'b0};
      default: return '{5'd31, 7'h00, 5'd31, 14'h0ABC, 2'd1, 1'b1}; // end capped
    endcase
  endfunction

  function automatic cfg_t random_setting();
    cfg_t s;
    s.last_scan_line    = SCAN_W'(($urandom_range(3) == 0) ? $urandom_range(31)
                                                           : $urandom_range(15));
    s.cursor_start_mode = START_MODE_W'($urandom);
    s.cursor_start_mode[SCAN_W-1:0] = SCAN_W'($urandom_range(17));
    s.cursor_end_line   = SCAN_W'(($urandom_range(7) == 0) ? 31 : $urandom_range(17));
    s.cursor_address    = CUR_ADDR_W'($urandom);
    if ($urandom_range(3) != 0) s.cursor_address[CUR_ADDR_W-1:CELL_ADDR_W] = '0;
    s.colour_mode       = COLOUR_MODE_W'($urandom);
    s.inverse_enable    = 1'($urandom);
    return s;
  endfunction

  // stop offering, then wait for every row and the in-flight tail
  task automatic settle_block();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pixel_rows_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // receiver: random stalls plus an optional long hold-off
  initial begin : receiver
    forever begin
      @(negedge clk_i);
      if (rx_hold != 0) begin
        m_axis_tready <= 1'b0;
        rx_hold--;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // compare every taken row with the oldest expected one
  always @(posedge clk_i) begin : check_pixels
    pix_row_t got;
    pix_row_t want;
    int       bad_pixel;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[NUM_PIXELS*PIX_W-1:0];
      if (pixel_rows_due.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("tb: pixel row %h with none expected", got);
      end else begin
        want = pixel_rows_due.pop_front();
        rows_checked++;
        bad_pixel = -1;
        for (int k = NUM_PIXELS - 1; k >= 0; k--) begin
          if (got[k] !== want[k]) bad_pixel = k;
        end
        if (bad_pixel >= 0) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("tb: row %0d pixel_%0d differs: expected %h, got %h",
                     rows_checked, bad_pixel, want, got);
          end
        end
      end
    end
  end

  // main sequence
  initial begin : main
    int unsigned phase_start;
    reg_shadow = '{5'd0, 7'd0, 5'd0, 14'd0, 2'd0, 1'b1};
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset settings
    foreach (directed_rows[i]) begin
      push_request(directed_rows[i].req, directed_rows[i].typed, directed_rows[i].pix);
    end

    // random phases, each with its own settings and traffic shape
    for (int p = 1; p <= NUM_PHASES; p++) begin
      settle_block();
      apply_setting((p <= NUM_FIXED) ? fixed_setting(p) : random_setting());
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1:       begin tx_idle_pct = 80; rx_stall_pct = 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct = 80; end
        default: begin tx_idle_pct = 12; rx_stall_pct = 12; end
      endcase
      // long receiver hold-off while requests keep coming
      if (p == 4) rx_hold = HOLD_OFF_CYCLES;
      phase_start = requests_taken;
      while (requests_taken - phase_start < PHASE_ITEMS) random_request();
    end
    settle_block();

    $display("tb: %0d requests over %0d register settings: %0d glyph writes, %0d frame starts,",
             requests_taken, settings_done, writes_taken, frames_taken);
    $display("tb: %0d pixel rows checked, %0d ignored requests, %0d mismatches",
             rows_checked, ignored_taken, mismatch_count);
    if (mismatch_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ----- text_cell_pixel_generator_with_cursor.f -----
hw/rtl/tcpg_pkg.sv
hw/rtl/tcpg_glyph_ram.sv
hw/rtl/tcpg_ctrl.sv
hw/rtl/tcpg_pixel_out.sv
hw/rtl/text_cell_pixel_generator_with_cursor.sv
hw/rtl/tcpg_checker.sv
tb/tb_top.sv
